// ===== hw/rtl/per_source_packet_reassembly_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the packet reassembly core
// Concurrent checks clocked on clk_i, switched off while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef PER_SOURCE_PACKET_REASSEMBLY_CORE_MACROS_SVH
`define PER_SOURCE_PACKET_REASSEMBLY_CORE_MACROS_SVH

// Plain property check
`define PSR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication check, consequent in the same cycle
`define PSR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/psr_pkg.sv =====
// ----------------------------------------------------------------------------
// psr_pkg
// Types and constants for the per-source packet reassembly core.
// ----------------------------------------------------------------------------
package psr_pkg;

  localparam int unsigned SRC_W    = 6;
  localparam int unsigned PKT_W    = 16;
  localparam int unsigned LEN_W    = 24;
  localparam int unsigned RANK_W   = 16;
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned MAXPL_W  = 16;

  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 72;

  localparam int unsigned MTU_BYTES = 1048;
  localparam int unsigned HDR_BYTES = 48;
  localparam logic [MAXPL_W-1:0] MAX_PAYLOAD_RST = MAXPL_W'(MTU_BYTES - HDR_BYTES);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_BUSY
  } state_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_PROGRESS   = 3'd0,
    STAT_COMPLETE   = 3'd1,
    STAT_FIRST_LONG = 3'd2,
    STAT_SHORT_MID  = 3'd3,
    STAT_OVERRUN    = 3'd4
  } status_e;

  // One reassembly table entry
  typedef struct packed {
    logic              expect_data;
    logic [LEN_W-1:0]  fill;
    logic [LEN_W-1:0]  total;
    logic [RANK_W-1:0] rank;
  } entry_t;

  typedef struct packed {
    logic [SRC_W-1:0]  src_node;
    logic [PKT_W-1:0]  pkt_len;
    logic [LEN_W-1:0]  hdr_msg_len;
    logic [RANK_W-1:0] hdr_rank;
  } item_t;

  typedef struct packed {
    logic [SRC_W-1:0]  src_node;
    status_e           status;
    logic [LEN_W-1:0]  msg_total;
    logic [LEN_W-1:0]  msg_fill;
    logic [RANK_W-1:0] msg_rank;
  } result_t;

endpackage

// ===== hw/rtl/per_source_packet_reassembly_core.sv =====
// ----------------------------------------------------------------------------
// per_source_packet_reassembly_core
// An accepted word is held with its table entry in item_q and rd_data_q; its
// result is then loaded into the output register once that register is free.
// A new word is taken only after the read-modify-write of the per-node table
// (synchronous read, then update and write back) for the last one. Reset: a
// clearing pass sets all entries to "expect header"; no input word is taken meanwhile.
// ----------------------------------------------------------------------------
module per_source_packet_reassembly_core #(
  parameter int unsigned NUM_NODES = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // config: max_payload
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [psr_pkg::MAXPL_W-1:0]     cfg_data_i,
  // tdata: src_node[5:0], pkt_len[21:6], hdr_msg_len[45:22], hdr_rank[61:46]
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [psr_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  // tdata: src_node_out[5:0], msg_total[29:6], msg_fill[53:30], msg_rank[69:54]
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  output logic [psr_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  // tuser: status[2:0]
  output logic [psr_pkg::STAT_W-1:0]      m_axis_tuser_o
);

  localparam int unsigned IDX_W     = $clog2(NUM_NODES);
  localparam int unsigned NODE_SPAN = 2 ** psr_pkg::SRC_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_NODES - 1);

  psr_pkg::state_e  state_q, state_d;
  logic [IDX_W-1:0] clr_cnt_q;
  logic [psr_pkg::MAXPL_W-1:0] max_payload_q;

  psr_pkg::item_t   in_item;
  psr_pkg::item_t   item_q;
  logic [IDX_W-1:0] idx_q;
  logic [IDX_W-1:0] node_map [NODE_SPAN];

  psr_pkg::entry_t  mem_q [NUM_NODES];
  psr_pkg::entry_t  rd_data_q;
  psr_pkg::entry_t  wr_data;
  logic [IDX_W-1:0] wr_addr;
  logic             wr_en;

  psr_pkg::result_t res_d, out_q;
  logic             out_valid_q;
  logic             accept, step;
  logic [psr_pkg::LEN_W:0] sum;

  // source node to table index (node modulo NUM_NODES)
  for (genvar g = 0; g < NODE_SPAN; g++) begin : g_node_map
    assign node_map[g] = IDX_W'(g % NUM_NODES);
  end

  assign in_item.src_node    = s_axis_tdata_i[5:0];
  assign in_item.pkt_len     = s_axis_tdata_i[21:6];
  assign in_item.hdr_msg_len = s_axis_tdata_i[45:22];
  assign in_item.hdr_rank    = s_axis_tdata_i[61:46];

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == psr_pkg::ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign step            = (state_q == psr_pkg::ST_BUSY) && (!out_valid_q || m_axis_tready_i);

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= psr_pkg::ST_CLEAR;
      clr_cnt_q     <= '0;
      max_payload_q <= psr_pkg::MAX_PAYLOAD_RST;
      out_valid_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == psr_pkg::ST_CLEAR) begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        max_payload_q <= cfg_data_i;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      psr_pkg::ST_CLEAR: begin
        if (clr_cnt_q == LAST_IDX) begin
          state_d = psr_pkg::ST_IDLE;
        end
      end
      psr_pkg::ST_IDLE: begin
        if (accept) begin
          state_d = psr_pkg::ST_BUSY;
        end
      end
      psr_pkg::ST_BUSY: begin
        if (step) begin
          state_d = psr_pkg::ST_IDLE;
        end
      end
      default: state_d = psr_pkg::ST_CLEAR;
    endcase
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item;
      idx_q  <= node_map[in_item.src_node];
    end
    if (step) begin
      out_q <= res_d;
    end
  end

  // reassembly table: one write port, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (accept) begin
      rd_data_q <= mem_q[node_map[in_item.src_node]];
    end
  end

  // update of the entry read for the word in hand
  always_comb begin
    sum = {1'b0, rd_data_q.fill} + (psr_pkg::LEN_W + 1)'(item_q.pkt_len);

    wr_data            = rd_data_q;
    res_d.src_node     = item_q.src_node;
    res_d.status       = psr_pkg::STAT_PROGRESS;
    res_d.msg_total    = rd_data_q.total;
    res_d.msg_fill     = rd_data_q.fill;
    res_d.msg_rank     = rd_data_q.rank;

    if (!rd_data_q.expect_data) begin
      res_d.msg_total = item_q.hdr_msg_len;
      res_d.msg_fill  = psr_pkg::LEN_W'(item_q.pkt_len);
      res_d.msg_rank  = item_q.hdr_rank;
      if (psr_pkg::LEN_W'(item_q.pkt_len) > item_q.hdr_msg_len) begin
        res_d.status = psr_pkg::STAT_FIRST_LONG;
      end else begin
        wr_data.total = item_q.hdr_msg_len;
        wr_data.fill  = psr_pkg::LEN_W'(item_q.pkt_len);
        wr_data.rank  = item_q.hdr_rank;
        if (psr_pkg::LEN_W'(item_q.pkt_len) == item_q.hdr_msg_len) begin
          res_d.status        = psr_pkg::STAT_COMPLETE;
          wr_data.expect_data = 1'b0;
        end else begin
          wr_data.expect_data = 1'b1;
        end
      end
    end else begin
      // short middle check goes first
      if (sum < {1'b0, rd_data_q.total} && item_q.pkt_len != max_payload_q) begin
        res_d.status        = psr_pkg::STAT_SHORT_MID;
        wr_data.expect_data = 1'b0;
      end else if (sum > {1'b0, rd_data_q.total}) begin
        res_d.status        = psr_pkg::STAT_OVERRUN;
        wr_data.expect_data = 1'b0;
      end else begin
        wr_data.fill   = sum[psr_pkg::LEN_W-1:0];
        res_d.msg_fill = sum[psr_pkg::LEN_W-1:0];
        if (sum == {1'b0, rd_data_q.total}) begin
          res_d.status        = psr_pkg::STAT_COMPLETE;
          wr_data.expect_data = 1'b0;
        end
      end
    end

    wr_en   = step;
    wr_addr = idx_q;
    if (state_q == psr_pkg::ST_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt_q;
      wr_data = '0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_q.status;
  assign m_axis_tdata_o  = {2'b00, out_q.msg_rank, out_q.msg_fill, out_q.msg_total,
                            out_q.src_node};

`include "per_source_packet_reassembly_core_macros.svh"

  `PSR_ASSERT_IMP(a_no_write_idle, wr_en, state_q != psr_pkg::ST_IDLE,
                  "table written while idle")
  `PSR_ASSERT_IMP(a_status_legal, m_axis_tvalid_o,
                  out_q.status <= psr_pkg::STAT_OVERRUN, "bad status")
  `PSR_ASSERT_IMP(a_complete_full,
                  m_axis_tvalid_o && out_q.status == psr_pkg::STAT_COMPLETE,
                  out_q.msg_fill == out_q.msg_total,
                  "complete with fill not equal to total")
  `PSR_ASSERT_IMP(a_progress_short,
                  m_axis_tvalid_o && out_q.status == psr_pkg::STAT_PROGRESS,
                  out_q.msg_fill < out_q.msg_total,
                  "in progress with fill at or past total")
  `PSR_ASSERT(a_busy_after_accept, accept |=> state_q == psr_pkg::ST_BUSY,
              "accepted word not taken into update")

endmodule
